// ===== hdl/rxmrb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the receive marker ring buffer.
// Shared operation codes, controller states and the command/status structs.
package rxmrb_pkg;

    typedef enum logic [1:0] {
        OP_RX    = 2'd0,
        OP_READ  = 2'd1,
        OP_COUNT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_WALK,
        ST_COUNT_WALK
    } state_t;

    // marker value held by a slot that was never written
    localparam logic [7:0] MARK_RESET = 8'hFF;
    // xor mask applied to the pad value when a slot is consumed
    localparam logic [7:0] MARK_FLIP  = 8'hFF;
    localparam logic [7:0] PAD_RESET  = 8'd59;
    localparam logic [7:0] COUNT_SAT  = 8'hFF;

    typedef struct packed {
        logic idle;        // read address tracks the read position
        logic req_ready;
        logic wr_rx;       // store a received byte
        logic start;       // set up a read or count walk
        logic rd_step;     // consume one new slot
        logic rd_finish;   // close the read request
        logic cnt_step;    // count one new slot
        logic cnt_finish;  // report the count
    } cmd_t;

    typedef struct packed {
        logic rd_stop;     // read length reached or slot not new
        logic cnt_stop;    // slot not new or whole ring counted
        logic out_free;    // output register can take a beat
    } stat_t;

endpackage

// ===== hdl/rxmrb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for the receive marker ring buffer.
// Request, response and configuration channels with valid/ready handshake.
interface rxmrb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [6:0] read_len;

    modport source (output valid, operation, rx_byte, read_len, input ready);
    modport sink   (input valid, operation, rx_byte, read_len, output ready);
endinterface

interface rxmrb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [7:0] avail_count;
    logic       last;

    modport source (output valid, data_byte, byte_valid, avail_count, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, avail_count, last, output ready);
endinterface

interface rxmrb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/rxmrb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the receive marker ring buffer.
// Decodes requests and sequences the slot walks; depends on rxmrb_pkg.
module rxmrb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        operation,
    input  rxmrb_pkg::stat_t  stat,
    output rxmrb_pkg::cmd_t   cmd
);

    rxmrb_pkg::state_t state_reg;
    rxmrb_pkg::state_t state_next;
    rxmrb_pkg::op_t    op;

    assign op = rxmrb_pkg::op_t'(operation);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rxmrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rxmrb_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (op)
                        rxmrb_pkg::OP_READ:  state_next = rxmrb_pkg::ST_READ_WALK;
                        rxmrb_pkg::OP_COUNT: state_next = rxmrb_pkg::ST_COUNT_WALK;
                        default:             state_next = rxmrb_pkg::ST_IDLE;
                    endcase
                end
            end
            rxmrb_pkg::ST_READ_WALK:
            begin
                if (stat.out_free && stat.rd_stop)
                begin
                    state_next = rxmrb_pkg::ST_IDLE;
                end
            end
            rxmrb_pkg::ST_COUNT_WALK:
            begin
                if (stat.out_free && stat.cnt_stop)
                begin
                    state_next = rxmrb_pkg::ST_IDLE;
                end
            end
            default: state_next = rxmrb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            rxmrb_pkg::ST_IDLE:
            begin
                cmd.idle      = 1'b1;
                cmd.req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (op)
                        rxmrb_pkg::OP_RX:    cmd.wr_rx = 1'b1;
                        rxmrb_pkg::OP_READ:  cmd.start = 1'b1;
                        rxmrb_pkg::OP_COUNT: cmd.start = 1'b1;
                        default:             cmd.wr_rx = 1'b0;
                    endcase
                end
            end
            rxmrb_pkg::ST_READ_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.rd_finish = stat.rd_stop;
                    cmd.rd_step   = !stat.rd_stop;
                end
            end
            rxmrb_pkg::ST_COUNT_WALK:
            begin
                cmd.cnt_step   = !stat.cnt_stop;
                cmd.cnt_finish = stat.cnt_stop && stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hdl/rxmrb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the receive marker ring buffer: slot memory, positions,
// walk counter and output register. Depends on rxmrb_pkg.
module rxmrb_datapath #(
    parameter int SLOTS    = 128,
    parameter int MAX_READ = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rxmrb_pkg::cmd_t   cmd,
    output rxmrb_pkg::stat_t  stat,
    input  logic [7:0]        rx_byte,
    input  logic [6:0]        read_len,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        data_byte,
    output logic              byte_valid,
    output logic [7:0]        avail_count,
    output logic              last
);

    localparam int PW    = $clog2(SLOTS);
    localparam int CW0   = $clog2(SLOTS + 1);
    localparam int CNT_W = (CW0 > 8) ? CW0 : 8;

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        pos_inc = (p == PW'(SLOTS - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    // {marker, data} per slot
    logic [15:0]       slot_mem [SLOTS];
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [15:0]       rd_word_reg;
    logic              rd_vld_reg;

    logic [7:0]        pad_reg;
    logic [PW-1:0]     write_pos_reg, write_pos_next;
    logic [PW-1:0]     read_pos_reg, read_pos_next;
    logic [PW-1:0]     walk_pos_reg, walk_pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [6:0]        len_reg, len_next;
    logic [7:0]        hold_data_reg, hold_data_next;
    logic              hold_vld_reg, hold_vld_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_bv_reg, out_bv_next;
    logic [7:0]        out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;

    logic              is_new;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [15:0]       wr_word;
    logic [PW-1:0]     rd_addr;
    logic [7:0]        cnt_sat;

    assign is_new = rd_vld_reg ? (rd_word_reg[15:8] == pad_reg)
                               : (pad_reg == rxmrb_pkg::MARK_RESET);

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.rd_stop  = (cnt_reg == CNT_W'(len_reg)) || !is_new;
    assign stat.cnt_stop = !is_new || (cnt_reg == CNT_W'(SLOTS));

    assign cnt_sat = (cnt_reg > CNT_W'(rxmrb_pkg::COUNT_SAT)) ? rxmrb_pkg::COUNT_SAT
                                                              : cnt_reg[7:0];

    assign wr_en   = cmd.wr_rx || cmd.rd_step;
    assign wr_addr = cmd.wr_rx ? write_pos_reg : walk_pos_reg;
    assign wr_word = cmd.wr_rx ? {pad_reg, rx_byte}
                               : {pad_reg ^ rxmrb_pkg::MARK_FLIP, 8'h00};

    // prefetch the next slot while the current one is decided
    assign rd_addr = (cmd.rd_step || cmd.cnt_step) ? pos_inc(walk_pos_reg)
                   : (cmd.idle ? read_pos_reg : walk_pos_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= slot_mem[rd_addr];
        rd_vld_reg  <= slot_valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            slot_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        write_pos_next = write_pos_reg;
        read_pos_next  = read_pos_reg;
        walk_pos_next  = walk_pos_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        hold_data_next = hold_data_reg;
        hold_vld_next  = hold_vld_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_bv_next    = out_bv_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;

        if (cmd.wr_rx)
        begin
            write_pos_next = pos_inc(write_pos_reg);
        end

        if (cmd.start)
        begin
            walk_pos_next = read_pos_reg;
            cnt_next      = '0;
            hold_vld_next = 1'b0;
            len_next      = (read_len > 7'(MAX_READ)) ? 7'(MAX_READ) : read_len;
        end

        // a consumed byte is held back one step until it is known whether it is last
        if (cmd.rd_step)
        begin
            if (hold_vld_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = hold_data_reg;
                out_bv_next    = 1'b1;
                out_cnt_next   = cnt_reg[7:0];
                out_last_next  = 1'b0;
            end
            hold_data_next = rd_word_reg[7:0];
            hold_vld_next  = 1'b1;
            cnt_next       = CNT_W'(cnt_reg + 1'b1);
            walk_pos_next  = pos_inc(walk_pos_reg);
        end

        if (cmd.rd_finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = hold_vld_reg ? hold_data_reg : 8'h00;
            out_bv_next    = hold_vld_reg;
            out_cnt_next   = hold_vld_reg ? cnt_reg[7:0] : 8'h00;
            out_last_next  = 1'b1;
            read_pos_next  = walk_pos_reg;
        end

        if (cmd.cnt_step)
        begin
            cnt_next      = CNT_W'(cnt_reg + 1'b1);
            walk_pos_next = pos_inc(walk_pos_reg);
        end

        if (cmd.cnt_finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = 8'h00;
            out_bv_next    = 1'b0;
            out_cnt_next   = cnt_sat;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg       <= rxmrb_pkg::PAD_RESET;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            hold_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pad_reg <= cfg_data;
            end
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            out_valid_reg <= out_valid_next;
            hold_vld_reg  <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_pos_reg  <= walk_pos_next;
        cnt_reg       <= cnt_next;
        len_reg       <= len_next;
        hold_data_reg <= hold_data_next;
        out_data_reg  <= out_data_next;
        out_bv_reg    <= out_bv_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = out_data_reg;
    assign byte_valid  = out_bv_reg;
    assign avail_count = out_cnt_reg;
    assign last        = out_last_reg;

endmodule

// ===== hdl/rx_marker_ring_buffer.sv =====
`timescale 1ns / 1ps
// Top level of the receive marker ring buffer.
// Uses rxmrb_pkg, the channel interfaces, rxmrb_ctrl and rxmrb_datapath.

// A received byte (operation 0) produces no beat; it overwrites its slot
// whether or not that slot was read. A read request walks the slot memory
// one slot per cycle, while the output register is free, through its
// single read port and returns one beat per byte, up to MAX_READ bytes, or
// one empty beat if no new slot is found. A count request walks the new
// slots, at most SLOTS, and returns their count in one beat. Per-slot valid
// bits stand for the reset value of the markers, so no clearing pass follows
// reset.
// The pad value may only be changed while no request is in progress.
module rx_marker_ring_buffer #(
    parameter int SLOTS    = 128,
    parameter int MAX_READ = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    rxmrb_req_if.sink    req,
    rxmrb_rsp_if.source  rsp,
    rxmrb_cfg_if.sink    cfg
);

    rxmrb_pkg::cmd_t  cmd;
    rxmrb_pkg::stat_t stat;

    assign req.ready = cmd.req_ready;
    assign cfg.ready = 1'b1;

    rxmrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .operation (req.operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    rxmrb_datapath #(
        .SLOTS    (SLOTS),
        .MAX_READ (MAX_READ)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .rx_byte     (req.rx_byte),
        .read_len    (req.read_len),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .data_byte   (rsp.data_byte),
        .byte_valid  (rsp.byte_valid),
        .avail_count (rsp.avail_count),
        .last        (rsp.last)
    );

    // a read or count request closes the input in the cycle after it is accepted
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.operation == rxmrb_pkg::OP_READ ||
        req.operation == rxmrb_pkg::OP_COUNT) |=> !req.ready)
        else $error("input open right after a walk request");

    // a received byte never leaves the block busy
    a_rx_single: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.operation == rxmrb_pkg::OP_RX |=> req.ready)
        else $error("received byte left the block busy");

    // empty beats carry zero data
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.byte_valid |-> rsp.data_byte == 8'h00 && rsp.last)
        else $error("empty beat with data or without last");

    // data beats are numbered from one and bounded by the read limit
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.byte_valid |->
        rsp.avail_count != 8'h00 && rsp.avail_count <= 8'(MAX_READ))
        else $error("read beat count out of range");

endmodule

// ===== bench/tb_rx_marker_ring_buffer.sv =====
`timescale 1ns / 1ps
// Testbench for rx_marker_ring_buffer: directed table, then random traffic over several pad values.
// Every response beat is checked against a scoreboard fed by a behavioral ring model.
// Depends on rxmrb_pkg, the rxmrb_*_if interfaces and the RTL under hdl/.
module tb_rx_marker_ring_buffer;

    localparam int SLOTS    = 128;
    localparam int MAX_READ = 64;
    localparam int QUIET_LIMIT = 4000;   // cycles with no beat on any channel
    localparam int SETTLE   = 8;
    localparam int PHASE_ITEMS = 16;
    localparam int FILL_BYTES  = 130;    // more than SLOTS, so the ring overruns
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic [7:0] cnt;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] b;
        logic [6:0] len;
        logic       typed;
        logic [7:0] w_data;
        logic       w_bval;
        logic [7:0] w_cnt;
        logic       w_last;
    } row_t;

    // Directed rows; expected beat typed in only where it is obvious.
    row_t plan [0:24] = '{
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd5,   1'b1, 8'h00, 1'b0, 8'd0, 1'b1},  // empty ring
        '{rxmrb_pkg::OP_COUNT, 8'h00, 7'd0,   1'b1, 8'h00, 1'b0, 8'd0, 1'b1},
        '{OP_UNUSED,           8'hFF, 7'd127, 1'b0, 8'h00, 1'b0, 8'd0, 1'b0},  // dropped
        '{rxmrb_pkg::OP_COUNT, 8'hFF, 7'd127, 1'b1, 8'h00, 1'b0, 8'd0, 1'b1},
        '{rxmrb_pkg::OP_RX,    8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'hFF, 7'd127, 1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'hA5, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'h5A, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_COUNT, 8'h00, 7'd0,   1'b1, 8'h00, 1'b0, 8'd4, 1'b1},
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd0,   1'b1, 8'h00, 1'b0, 8'd0, 1'b1},  // zero length
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd1,   1'b1, 8'h00, 1'b1, 8'd1, 1'b1},
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd127, 1'b0, 8'h00, 1'b0, 8'd0, 1'b0},  // clipped length
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd64,  1'b1, 8'h00, 1'b0, 8'd0, 1'b1},
        '{rxmrb_pkg::OP_COUNT, 8'h00, 7'd0,   1'b1, 8'h00, 1'b0, 8'd0, 1'b1},
        '{rxmrb_pkg::OP_RX,    8'h80, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'h7F, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'h01, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd64,  1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'h11, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'h22, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_RX,    8'h33, 7'd0,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd2,   1'b0, 8'h00, 1'b0, 8'd0, 1'b0},
        '{rxmrb_pkg::OP_COUNT, 8'h00, 7'd0,   1'b1, 8'h00, 1'b0, 8'd1, 1'b1},
        '{rxmrb_pkg::OP_READ,  8'h00, 7'd65,  1'b1, 8'h33, 1'b1, 8'd1, 1'b1},
        '{rxmrb_pkg::OP_COUNT, 8'h00, 7'd0,   1'b1, 8'h00, 1'b0, 8'd0, 1'b1}
    };

    logic clk;
    logic rst_n;

    rxmrb_req_if req();
    rxmrb_rsp_if rsp();
    rxmrb_cfg_if cfg();

    rx_marker_ring_buffer #(
        .SLOTS    (SLOTS),
        .MAX_READ (MAX_READ)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // ring state as the bench sees it
    logic [7:0] ring_data [SLOTS];
    logic [7:0] ring_mark [SLOTS];
    logic [6:0] wr_ptr;
    logic [6:0] rd_ptr;
    logic [7:0] pad;

    beat_t beats_due [$];
    logic  typed_next;
    beat_t typed_beat;

    int gap_pct;
    int stall_pct;
    int errors;
    int reqs_done;
    int beats_seen;
    int pads_used;
    int quiet;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one request to the ring and queue the beats it must produce.
    task automatic step_ring(input logic [1:0] op, input logic [7:0] b, input logic [6:0] len);
        int lim;
        int n;
        logic [6:0] p;
        beat_t bt;
        case (op)
            rxmrb_pkg::OP_RX:
            begin
                ring_data[wr_ptr] = b;
                ring_mark[wr_ptr] = pad;
                wr_ptr = wr_ptr + 7'd1;
            end
            rxmrb_pkg::OP_READ:
            begin
                lim = (len > MAX_READ) ? MAX_READ : int'(len);
                n = 0;
                while (n < lim && ring_mark[rd_ptr] == pad)
                begin
                    p = rd_ptr + 7'd1;
                    bt.data = ring_data[rd_ptr];
                    bt.bval = 1'b1;
                    bt.cnt  = 8'(n + 1);
                    bt.last = (n + 1 == lim) || (ring_mark[p] != pad);
                    beats_due.push_back(bt);
                    ring_mark[rd_ptr] = pad ^ rxmrb_pkg::MARK_FLIP;
                    ring_data[rd_ptr] = 8'h00;
                    rd_ptr = p;
                    n++;
                end
                if (n == 0)
                    beats_due.push_back(beat_t'{8'h00, 1'b0, 8'h00, 1'b1});
            end
            rxmrb_pkg::OP_COUNT:
            begin
                n = 0;
                p = rd_ptr;
                while (n < SLOTS && ring_mark[p] == pad)
                begin
                    n++;
                    p = p + 7'd1;
                end
                bt.data = 8'h00;
                bt.bval = 1'b0;
                bt.cnt  = (n > rxmrb_pkg::COUNT_SAT) ? rxmrb_pkg::COUNT_SAT : n[7:0];
                bt.last = 1'b1;
                beats_due.push_back(bt);
            end
            default: ;
        endcase
    endtask

    // Called right after a falling edge; returns right after one.
    task automatic push_req(input logic [1:0] op, input logic [7:0] b, input logic [6:0] len);
        int sz;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.rx_byte   <= b;
        req.read_len  <= len;
        do @(posedge clk); while (!req.ready);
        sz = beats_due.size();
        step_ring(op, b, len);
        if (typed_next)
        begin
            while (beats_due.size() > sz)
                beats_due.delete(beats_due.size() - 1);
            beats_due.push_back(typed_beat);
            typed_next = 1'b0;
        end
        if (op != OP_UNUSED)
            reqs_done++;
        @(negedge clk);
    endtask

    task automatic write_pad(input logic [7:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do @(posedge clk); while (!cfg.ready);
        pad = v;
        pads_used++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        while (beats_due.size() != 0)
            @(negedge clk);
        // received bytes give no beat; let the last one land
        repeat (SETTLE) @(negedge clk);
    endtask

    // Mostly byte bursts and reads of them, with counts, long reads and dropped ops mixed in.
    task automatic run_phase(input int n_items);
        int done;
        int pick;
        int burst;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst)
                    push_req(rxmrb_pkg::OP_RX, 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)));
                done += burst;
            end
            else if (pick < 7)
            begin
                push_req(rxmrb_pkg::OP_READ, 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 16)));
                done++;
            end
            else if (pick == 7)
            begin
                push_req(rxmrb_pkg::OP_READ, 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)));
                done++;
            end
            else if (pick == 8)
            begin
                push_req(rxmrb_pkg::OP_COUNT, 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)));
                done++;
            end
            else if ($urandom_range(0, 1) == 1)
                push_req(OP_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            else
            begin
                push_req(rxmrb_pkg::OP_READ, 8'($urandom_range(0, 255)),
                         7'($urandom_range(MAX_READ, 127)));
                done++;
            end
        end
        req.valid <= 1'b0;
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic flag(input string what, input logic [7:0] want, input logic [7:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_beats
        beat_t got;
        beat_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.data_byte, rsp.byte_valid, rsp.avail_count, rsp.last};
            beats_seen++;
            if (beats_due.size() == 0)
            begin
                errors++;
                $display("%0t: beat with nothing expected, got %0h", $time, got);
            end
            else
            begin
                want = beats_due.pop_front();
                if (got.data !== want.data)
                    flag("data_byte", want.data, got.data);
                if (got.bval !== want.bval)
                    flag("byte_valid", {7'd0, want.bval}, {7'd0, got.bval});
                if (got.cnt !== want.cnt)
                    flag("avail_count", want.cnt, got.cnt);
                if (got.last !== want.last)
                    flag("last", {7'd0, want.last}, {7'd0, got.last});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet <= 0;
        else if (quiet + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d beats still due",
                     $time, QUIET_LIMIT, beats_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin : main
        logic [7:0] mid_pad;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = rxmrb_pkg::OP_RX;
        req.rx_byte = 8'h00;
        req.read_len = 7'd0;
        cfg.valid = 1'b0;
        cfg.data = 8'h00;
        gap_pct = 0;
        stall_pct = 0;
        errors = 0;
        reqs_done = 0;
        beats_seen = 0;
        pads_used = 1;
        quiet = 0;
        typed_next = 1'b0;
        typed_beat = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            ring_data[i] = 8'h00;
            ring_mark[i] = rxmrb_pkg::MARK_RESET;
        end
        wr_ptr = 7'd0;
        rd_ptr = 7'd0;
        pad = rxmrb_pkg::PAD_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 25; i++)
        begin
            typed_next = plan[i].typed;
            typed_beat = '{plan[i].w_data, plan[i].w_bval, plan[i].w_cnt, plan[i].w_last};
            push_req(plan[i].op, plan[i].b, plan[i].len);
        end
        run_phase(PHASE_ITEMS);
        drain();

        // pad 0 with a full overrun: afterwards every slot has been written,
        // so an all-ones pad can never expose an unwritten slot
        write_pad(8'h00);
        gap_pct = 59;
        repeat (FILL_BYTES)
            push_req(rxmrb_pkg::OP_RX, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        push_req(rxmrb_pkg::OP_COUNT, 8'h00, 7'd0);
        run_phase(PHASE_ITEMS);
        drain();

        write_pad(8'hFF);
        gap_pct = 0;
        stall_pct = 59;
        run_phase(PHASE_ITEMS);
        drain();

        mid_pad = 8'($urandom_range(1, 254));
        write_pad(mid_pad);
        gap_pct = 10;
        stall_pct = 10;
        run_phase(PHASE_ITEMS);
        drain();

        // flipped pad turns already consumed slots back into new ones
        write_pad(mid_pad ^ rxmrb_pkg::MARK_FLIP);
        gap_pct = 59;
        stall_pct = 0;
        run_phase(PHASE_ITEMS);
        drain();

        write_pad(rxmrb_pkg::PAD_RESET);
        gap_pct = 10;
        stall_pct = 10;
        run_phase(PHASE_ITEMS);
        drain();

        $display("Checked %0d requests and %0d response beats across %0d pad settings,",
                 reqs_done, beats_seen, pads_used);
        $display("including ring overrun, clipped reads and sender/receiver throttling.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
